// ===== rtl/nec_tx_pkg.sv =====
// Shared types and constants for the NEC infrared frame transmitter.
// No dependencies; imported by every module of the transmitter.
`default_nettype none

package nec_tx_pkg;

    typedef struct packed {
        logic        op;
        logic [31:0] message;
    } t_in_word;

    typedef struct packed {
        logic ir_out;
        logic busy_res;
        logic frame_done;
    } t_out_word;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4,
        PH_STOP_MARK  = 3'd5
    } t_phase;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 12;
    localparam int DivW      = 10;
    localparam int UnitW     = 12;

    localparam logic [CfgIndexW-1:0] CFG_CARRIER_HALF = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_UNIT_DIV     = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_LEAD_MARK    = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_LEAD_SPACE   = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_BIT_MARK     = 3'd4;
    localparam logic [CfgIndexW-1:0] CFG_ONE_SPACE    = 3'd5;
    localparam logic [CfgIndexW-1:0] CFG_ZERO_SPACE   = 3'd6;

    localparam logic [DivW-1:0]  RST_CARRIER_HALF = 10'd211;
    localparam logic [DivW-1:0]  RST_UNIT_DIV     = 10'd160;
    localparam logic [UnitW-1:0] RST_LEAD_MARK    = 12'd900;
    localparam logic [UnitW-1:0] RST_LEAD_SPACE   = 12'd450;
    localparam logic [UnitW-1:0] RST_BIT_MARK     = 12'd56;
    localparam logic [UnitW-1:0] RST_ONE_SPACE    = 12'd169;
    localparam logic [UnitW-1:0] RST_ZERO_SPACE   = 12'd56;

endpackage

`default_nettype wire

// ===== rtl/nec_tx_carrier.sv =====
// Square-wave carrier for the NEC transmitter; it advances only while i_step is high.
// Depends on nec_tx_pkg for the divider width.
`default_nettype none

module nec_tx_carrier
    import nec_tx_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [DivW-1:0] i_half_period,
    output logic                 o_level
);

    logic [DivW-1:0] r_count;
    logic [DivW-1:0] n_count;
    logic            r_level;
    logic            n_level;
    logic [DivW-1:0] count_inc;

    always_comb begin
        count_inc = r_count + DivW'(1);
        if (count_inc >= i_half_period) begin
            n_count = '0;
            n_level = ~r_level;
        end else begin
            n_count = count_inc;
            n_level = r_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_level <= 1'b0;
        end else if (i_step) begin
            r_count <= n_count;
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

`default_nettype wire

// ===== rtl/nec_ir_frame_transmitter_unit.sv =====
// Top level of the NEC infrared frame transmitter: configuration registers,
// frame sequencer and output skid stage. Depends on nec_tx_pkg and nec_tx_carrier.
// The result word for an accepted input word is registered in the output register,
// or held in the skid word while the output stalls. Throughput: one input word per
// cycle, limited only by the output stall. Reset: synchronous, active low; clears the
// sequencer, carrier and output stage and loads the configuration registers with their default timing values.
`default_nettype none

module nec_ir_frame_transmitter_unit
    import nec_tx_pkg::*;
#(
    parameter int FRAME_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire t_in_word             i_in_word,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output t_out_word                 o_out_word,
    input  wire logic                 i_out_stall,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CfgIndexW-1:0] i_cfg_index,
    input  wire logic [CfgDataW-1:0]  i_cfg_data,
    output logic                      o_cfg_ready
);

    localparam int PosW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BITS - 1);

    logic [DivW-1:0]  r_carrier_half;
    logic [DivW-1:0]  r_unit_div;
    logic [UnitW-1:0] r_lead_mark;
    logic [UnitW-1:0] r_lead_space;
    logic [UnitW-1:0] r_bit_mark;
    logic [UnitW-1:0] r_one_space;
    logic [UnitW-1:0] r_zero_space;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [PosW-1:0]  r_pos;
    logic [PosW-1:0]  n_pos;
    logic [31:0]      r_shift;
    logic [31:0]      n_shift;
    logic [UnitW-1:0] r_cnt;
    logic [UnitW-1:0] n_cnt;
    logic [DivW-1:0]  r_pre;
    logic [DivW-1:0]  n_pre;

    logic             start;
    t_phase           cur_phase;
    logic [PosW-1:0]  cur_pos;
    logic [31:0]      cur_shift;
    logic [UnitW-1:0] cur_cnt;
    logic [DivW-1:0]  cur_pre;
    logic [DivW-1:0]  pre_inc;
    logic [UnitW-1:0] cnt_inc;
    logic [UnitW-1:0] len_raw;
    logic [UnitW-1:0] len_eff;
    logic             busy;
    logic             unit_tick;
    logic             interval_end;
    logic             done;
    logic             carrier_level;

    t_out_word        step_word;
    logic             in_fire;
    logic             out_fire;
    logic             r_ov;
    t_out_word        r_out;
    logic             r_sv;
    t_out_word        r_skid;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carrier_half <= RST_CARRIER_HALF;
            r_unit_div     <= RST_UNIT_DIV;
            r_lead_mark    <= RST_LEAD_MARK;
            r_lead_space   <= RST_LEAD_SPACE;
            r_bit_mark     <= RST_BIT_MARK;
            r_one_space    <= RST_ONE_SPACE;
            r_zero_space   <= RST_ZERO_SPACE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CARRIER_HALF: r_carrier_half <= i_cfg_data[DivW-1:0];
                CFG_UNIT_DIV:     r_unit_div     <= i_cfg_data[DivW-1:0];
                CFG_LEAD_MARK:    r_lead_mark    <= i_cfg_data;
                CFG_LEAD_SPACE:   r_lead_space   <= i_cfg_data;
                CFG_BIT_MARK:     r_bit_mark     <= i_cfg_data;
                CFG_ONE_SPACE:    r_one_space    <= i_cfg_data;
                CFG_ZERO_SPACE:   r_zero_space   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    nec_tx_carrier u_carrier (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_fire),
        .i_half_period (r_carrier_half),
        .o_level       (carrier_level)
    );

    // A start request while idle makes this word the first of the lead mark.
    always_comb begin
        start     = (r_phase == PH_IDLE) && i_in_word.op;
        cur_phase = start ? PH_LEAD_MARK : r_phase;
        cur_pos   = start ? '0 : r_pos;
        cur_shift = start ? i_in_word.message : r_shift;
        cur_cnt   = start ? '0 : r_cnt;
        cur_pre   = start ? '0 : r_pre;
        busy      = (cur_phase != PH_IDLE);
    end

    always_comb begin
        unique case (cur_phase)
            PH_LEAD_MARK:  len_raw = r_lead_mark;
            PH_LEAD_SPACE: len_raw = r_lead_space;
            PH_BIT_MARK:   len_raw = r_bit_mark;
            PH_BIT_SPACE:  len_raw = cur_shift[0] ? r_one_space : r_zero_space;
            PH_STOP_MARK:  len_raw = r_bit_mark;
            default:       len_raw = UnitW'(1);
        endcase
        len_eff = (len_raw == '0) ? UnitW'(1) : len_raw;
    end

    // Next state.
    always_comb begin
        pre_inc      = cur_pre + DivW'(1);
        cnt_inc      = cur_cnt + UnitW'(1);
        unit_tick    = busy && (pre_inc >= r_unit_div);
        interval_end = unit_tick && (cnt_inc >= len_eff);
        n_phase      = cur_phase;
        n_pos        = cur_pos;
        n_shift      = cur_shift;
        n_cnt        = cur_cnt;
        n_pre        = cur_pre;
        done         = 1'b0;
        if (busy) begin
            n_pre = unit_tick ? '0 : pre_inc;
            n_cnt = unit_tick ? cnt_inc : cur_cnt;
        end
        if (interval_end) begin
            n_pre = '0;
            n_cnt = '0;
            unique case (cur_phase)
                PH_LEAD_MARK:  n_phase = PH_LEAD_SPACE;
                PH_LEAD_SPACE: n_phase = PH_BIT_MARK;
                PH_BIT_MARK:   n_phase = PH_BIT_SPACE;
                PH_BIT_SPACE: begin
                    if (cur_pos == LastPos) begin
                        n_phase = PH_STOP_MARK;
                    end else begin
                        n_phase = PH_BIT_MARK;
                        n_pos   = cur_pos + PosW'(1);
                        n_shift = {1'b0, cur_shift[31:1]};
                    end
                end
                PH_STOP_MARK: begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Outputs of this word.
    always_comb begin
        step_word.ir_out     = ((cur_phase == PH_LEAD_MARK) || (cur_phase == PH_BIT_MARK) ||
                                (cur_phase == PH_STOP_MARK)) && carrier_level;
        step_word.busy_res   = busy;
        step_word.frame_done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_shift <= '0;
            r_cnt   <= '0;
            r_pre   <= '0;
        end else if (in_fire) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
            r_pre   <= n_pre;
        end
    end

    // Output register with a skid word behind it.
    assign o_in_stall  = r_sv;
    assign in_fire     = i_in_valid && !r_sv;
    assign out_fire    = r_ov && !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || out_fire) begin
            r_ov <= r_sv || in_fire;
            r_sv <= 1'b0;
        end else if (in_fire) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || out_fire) begin
            r_out <= r_sv ? r_skid : step_word;
        end else if (in_fire) begin
            r_skid <= step_word;
        end
    end

    a_idle_counters_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_cnt == '0 && r_pre == '0))
        else $error("interval counters not cleared while idle");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LastPos)
        else $error("bit position beyond frame length");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid word held with empty output register");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.frame_done) |-> r_out.busy_res)
        else $error("frame end reported outside a frame");

    a_ir_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.ir_out) |-> r_out.busy_res)
        else $error("carrier driven while idle");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && done) |=> (r_phase == PH_IDLE))
        else $error("sequencer not idle after frame end");

endmodule

`default_nettype wire
